// ===== design/fnvhs_pkg.sv =====
// ----------------------------------------------------------------------------
// fnvhs_pkg
// shared types, operation codes and hash constants of the fnv-1a history set
// ----------------------------------------------------------------------------
`default_nettype none

package fnvhs_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 512;

  localparam int unsigned HASH_W  = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned COUNT_W = 10;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'd1469598103934665603;
  // prime is 2^40 + 0x1b3
  localparam int unsigned       PRIME_HI_SHIFT = 40;
  localparam int unsigned       PRIME_MID_SHIFT = 8;
  localparam logic [HASH_W-1:0] PRIME_LOW = 64'hB3;

  localparam logic [OP_W-1:0] OP_ABSORB = 2'd0;
  localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data_byte;
  } req_item_t;

  typedef struct packed {
    logic [HASH_W-1:0]  hash_value;
    logic               seen;
    logic               stored;
    logic [COUNT_W-1:0] entry_count;
  } rsp_item_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic scan;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/fnv1a_history_set.sv =====
// ----------------------------------------------------------------------------
// fnv1a_history_set
// byte-serial 64-bit fnv-1a-style hasher (fnv prime, non-standard basis) with a record/query history of hashes
// ----------------------------------------------------------------------------
// Bytes, records and clears are taken one item per cycle; the hash fold is
// combinational. The history is a row of HISTORY_DEPTH cells, newest entry
// in the first cell, older ones shifted along. A query holds the input while
// a hit bit walks from cell to cell one step per cycle toward the first cell,
// and the answer is read there once every held entry has been passed. The
// input also waits while a result is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv1a_history_set
  import fnvhs_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire req_item_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output rsp_item_t      rsp
);

  localparam int unsigned CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned EXT_W = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_SCAN = 1'b1;

  logic [0:0]        state;
  logic [CW-1:0]     fill_count;
  logic [CW-1:0]     fill_count_next;
  logic [CW-1:0]     scan_cnt;
  logic [HASH_W-1:0] query_hash;
  logic [HASH_W-1:0] folded;
  logic              accept;
  logic              room;
  logic [EXT_W-1:0]  count_ext;
  cell_ctrl_t        ctrl;

  logic [HASH_W-1:0] entry_chain [HISTORY_DEPTH+1];
  logic              hit_chain   [HISTORY_DEPTH+1];

  assign req_ready = (state == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign room      = fill_count < CW'(HISTORY_DEPTH);

  always_comb begin
    fill_count_next = fill_count;
    if (accept && req.operation == OP_CLEAR) begin
      fill_count_next = '0;
    end else if (accept && req.operation == OP_RECORD && room) begin
      fill_count_next = fill_count + 1'b1;
    end
    count_ext = EXT_W'(fill_count_next);
  end

  always_comb begin
    ctrl.shift = accept && (req.operation == OP_RECORD) && room;
    ctrl.clear = accept && (req.operation == OP_QUERY);
    ctrl.scan  = (state == ST_SCAN) && (scan_cnt != '0);
  end

  fnvhs_hasher u_hasher (
    .clk       (clk),
    .rst       (rst),
    .take      (accept),
    .operation (req.operation),
    .data_byte (req.data_byte),
    .folded    (folded)
  );

  assign entry_chain[0]           = folded;
  assign hit_chain[HISTORY_DEPTH] = 1'b0;

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    fnvhs_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .entry_in   (entry_chain[i]),
      .query_hash (query_hash),
      .hit_in     (hit_chain[i+1]),
      .entry_out  (entry_chain[i+1]),
      .hit_out    (hit_chain[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      unique case (state)
        ST_IDLE: begin
          if (accept && req.operation == OP_RECORD) begin
            rsp_valid <= 1'b1;
          end else begin
            if (rsp_ready) begin
              rsp_valid <= 1'b0;
            end
            if (accept && req.operation == OP_QUERY) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_cnt == '0) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
          end
        end
      endcase
    end
  end

  // payload side
  always_ff @(posedge clk) begin
    if (accept && req.operation == OP_RECORD) begin
      rsp.hash_value  <= folded;
      rsp.seen        <= 1'b0;
      rsp.stored      <= room;
      rsp.entry_count <= count_ext[COUNT_W-1:0];
    end
    if (accept && req.operation == OP_QUERY) begin
      query_hash      <= folded;
      scan_cnt        <= fill_count;
      rsp.hash_value  <= folded;
      rsp.stored      <= 1'b0;
      rsp.entry_count <= count_ext[COUNT_W-1:0];
    end
    if (state == ST_SCAN) begin
      if (scan_cnt == '0) begin
        rsp.seen <= hit_chain[0];
      end else begin
        scan_cnt <= scan_cnt - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(HISTORY_DEPTH))
    else $error("history count beyond depth");

  a_record_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req.operation == OP_RECORD && room) |=>
      (fill_count == $past(fill_count) + 1'b1) && rsp_valid && rsp.stored)
    else $error("record with room not stored");

  a_query_waits: assert property (@(posedge clk) disable iff (rst)
    (accept && req.operation == OP_QUERY) |=> !rsp_valid && !req_ready)
    else $error("query answered before scan");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && req.operation == OP_CLEAR) |=> fill_count == '0)
    else $error("clear left entries");

endmodule

`default_nettype wire

// ===== design/fnvhs_hasher.sv =====
// ----------------------------------------------------------------------------
// fnvhs_hasher
// running fnv-1a hash register and the byte fold
// ----------------------------------------------------------------------------
`default_nettype none

module fnvhs_hasher
  import fnvhs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [OP_W-1:0]   operation,
  input  wire logic [BYTE_W-1:0] data_byte,
  output logic      [HASH_W-1:0] folded
);

  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] mixed;

  always_comb begin
    mixed  = running_hash ^ HASH_W'(data_byte);
    folded = (mixed << PRIME_HI_SHIFT) + (mixed << PRIME_MID_SHIFT) + (mixed * PRIME_LOW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
    end else if (take) begin
      if (operation == OP_ABSORB) begin
        running_hash <= folded;
      end else begin
        running_hash <= FNV_BASIS;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/fnvhs_cell.sv =====
// ----------------------------------------------------------------------------
// fnvhs_cell
// one history entry with its slot of the shifting hit chain
// ----------------------------------------------------------------------------
`default_nettype none

module fnvhs_cell
  import fnvhs_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [HASH_W-1:0] entry_in,
  input  wire logic [HASH_W-1:0] query_hash,
  input  wire logic              hit_in,
  output logic      [HASH_W-1:0] entry_out,
  output logic                   hit_out
);

  logic [HASH_W-1:0] entry;
  logic              hit;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      entry <= entry_in;
    end
    if (ctrl.clear) begin
      hit <= 1'b0;
    end else if (ctrl.scan) begin
      hit <= hit_in | (entry == query_hash);
    end
  end

  assign entry_out = entry;
  assign hit_out   = hit;

endmodule

`default_nettype wire
